// File: rtl/sttt_pkg.sv
// ----------------------------------------------------------------------------
// sttt_pkg
// Shared types, constants and helpers of the session translation table.
// ----------------------------------------------------------------------------
package sttt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int TAW           = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = TAW + 1;

	// item queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	localparam int WORD_SHIFT = 2;   // words to bytes

	// command codes on the input
	localparam logic [1:0] CMD_PASS    = 2'd0;
	localparam logic [1:0] CMD_INSTALL = 2'd1;

	typedef enum logic [1:0] {
		OP_PASS    = 2'd0,
		OP_INSTALL = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	typedef struct packed {
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
	} tuple_t;

	localparam int TUPLE_W = $bits(tuple_t);

	typedef struct packed {
		op_t         op;
		tuple_t      pkt;
		tuple_t      sup;
		logic [15:0] ip_len;
		logic [15:0] trim;
	} item_t;

	typedef struct packed {
		tuple_t      tup;
		logic [15:0] ip_len;
		logic [15:0] trim;
		logic        hit;
		logic        full;
	} result_t;

	// swap addresses and ports
	function automatic tuple_t rev_tuple(input tuple_t t);
		tuple_t r;
		r.sa = t.da;
		r.da = t.sa;
		r.sp = t.dp;
		r.dp = t.sp;
		return r;
	endfunction

endpackage

// File: rtl/sttt_ram.sv
// ----------------------------------------------------------------------------
// sttt_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module sttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// storage and read register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/sttt_front.sv
// ----------------------------------------------------------------------------
// sttt_front
// Accepts header transactions, decodes the command, works out the payload
// trim and new length, and queues the item for the table engine.
// ----------------------------------------------------------------------------
module sttt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [31:0]          src_addr,
	input  logic [31:0]          dst_addr,
	input  logic [15:0]          src_tcp_port,
	input  logic [15:0]          dst_tcp_port,
	input  logic [31:0]          super_src_addr,
	input  logic [31:0]          super_dst_addr,
	input  logic [15:0]          super_src_port,
	input  logic [15:0]          super_dst_port,
	input  logic [15:0]          ip_total_length,
	input  logic [3:0]           ip_header_words,
	input  logic [3:0]           tcp_offset_words,
	output logic                 q_valid,
	input  logic                 q_pop,
	output sttt_pkg::item_t      q_item
);
	import sttt_pkg::*;

	item_t       item;
	logic [4:0]  hdr_words;
	logic [6:0]  hdr_bytes;
	logic [15:0] hdr_ext;
	logic        has_payload;
	logic        push;

	item_t          fifo_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   fill_q;

	// header size and payload clamp
	always_comb begin
		hdr_words   = {1'b0, ip_header_words} + {1'b0, tcp_offset_words};
		hdr_bytes   = {hdr_words, {WORD_SHIFT{1'b0}}};
		hdr_ext     = {9'd0, hdr_bytes};
		has_payload = ip_total_length > hdr_ext;
	end

	// classify
	always_comb begin
		item.pkt    = '{sa: src_addr, da: dst_addr, sp: src_tcp_port, dp: dst_tcp_port};
		item.sup    = '{sa: super_src_addr, da: super_dst_addr,
		                sp: super_src_port, dp: super_dst_port};
		item.ip_len = ip_total_length;
		item.trim   = '0;
		case (cmd)
			CMD_PASS: begin
				item.op = OP_PASS;
			end
			CMD_INSTALL: begin
				item.op = OP_INSTALL;
				if (has_payload) begin
					item.trim   = ip_total_length - hdr_ext;
					item.ip_len = hdr_ext;
				end
			end
			default: begin
				item.op = OP_LOOKUP;
			end
		endcase
	end

	assign in_stall = (fill_q == (QAW+1)'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (q_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/sttt_back.sv
// ----------------------------------------------------------------------------
// sttt_back
// Table engine: scans the key memory for a tuple, reads the mapped tuple on
// a lookup hit, performs the four inserts of an install, and holds the
// result register.
// ----------------------------------------------------------------------------
module sttt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  sttt_pkg::item_t      q_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sttt_pkg::result_t    res
);
	import sttt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_VRD  = 6'b001000,
		ST_WR   = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t           st_q;
	item_t            cur_q;
	logic [1:0]       step_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic             found_q;
	logic             hit_q;
	logic             full_q;
	tuple_t           map_q;
	result_t          out_q;
	logic             out_vld_q;

	tuple_t           key;
	tuple_t           val;
	logic [TAW-1:0]   addr;
	logic             key_we;
	logic             val_we;
	tuple_t           key_rd;
	tuple_t           val_rd;
	logic             last_step;
	logic             out_free;
	result_t          nxt_res;

	// key and value of the current insert step
	always_comb begin
		case (step_q)
			2'd0: begin
				key = cur_q.pkt;
				val = cur_q.sup;
			end
			2'd1: begin
				key = cur_q.sup;
				val = cur_q.pkt;
			end
			2'd2: begin
				key = rev_tuple(cur_q.pkt);
				val = rev_tuple(cur_q.sup);
			end
			default: begin
				key = rev_tuple(cur_q.sup);
				val = rev_tuple(cur_q.pkt);
			end
		endcase
		// lookups search the packet tuple
		if (cur_q.op == OP_LOOKUP) begin
			key = cur_q.pkt;
		end
	end

	// memory port control
	assign key_we = (st_q == ST_WR) && !found_q;
	assign val_we = (st_q == ST_WR);
	assign addr   = key_we ? count_q[TAW-1:0] : idx_q[TAW-1:0];

	sttt_ram #(.WIDTH(TUPLE_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.addr  (addr),
		.wdata (key),
		.rdata (key_rd)
	);

	sttt_ram #(.WIDTH(TUPLE_W), .DEPTH(TABLE_ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.addr  (addr),
		.wdata (val),
		.rdata (val_rd)
	);

	assign last_step = (step_q == 2'd3);
	assign out_free  = !out_vld_q || !out_stall;
	assign q_pop     = (st_q == ST_IDLE) && q_valid;

	// result assembly
	always_comb begin
		nxt_res.ip_len = cur_q.ip_len;
		nxt_res.trim   = cur_q.trim;
		nxt_res.hit    = hit_q;
		nxt_res.full   = full_q;
		case (cur_q.op)
			OP_INSTALL: nxt_res.tup = cur_q.sup;
			OP_LOOKUP:  nxt_res.tup = hit_q ? map_q : cur_q.pkt;
			default:    nxt_res.tup = cur_q.pkt;
		endcase
	end

	// item payload and mapped tuple
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (st_q == ST_VRD) begin
			map_q <= val_rd;
		end
		if ((st_q == ST_OUT) && out_free) begin
			out_q <= nxt_res;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			step_q    <= '0;
			idx_q     <= '0;
			count_q   <= '0;
			found_q   <= 1'b0;
			hit_q     <= 1'b0;
			full_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// result register: load a new transaction or drop the taken one
			if ((st_q == ST_OUT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						step_q  <= '0;
						idx_q   <= '0;
						found_q <= 1'b0;
						hit_q   <= 1'b0;
						full_q  <= 1'b0;
						st_q    <= (q_item.op == OP_PASS) ? ST_OUT : ST_RD;
					end
				end
				ST_RD: begin
					if (idx_q == count_q) begin
						// key not present
						found_q <= 1'b0;
						if (cur_q.op == OP_LOOKUP) begin
							st_q <= ST_OUT;
						end else if (count_q == CNT_W'(TABLE_ENTRIES)) begin
							full_q <= 1'b1;
							if (last_step) begin
								st_q <= ST_OUT;
							end else begin
								step_q <= step_q + 1'b1;
								idx_q  <= '0;
								st_q   <= ST_RD;
							end
						end else begin
							st_q <= ST_WR;
						end
					end else begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (key_rd == key) begin
						found_q <= 1'b1;
						st_q    <= (cur_q.op == OP_LOOKUP) ? ST_VRD : ST_WR;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= ST_RD;
					end
				end
				ST_VRD: begin
					hit_q <= 1'b1;
					st_q  <= ST_OUT;
				end
				ST_WR: begin
					if (!found_q) begin
						count_q <= count_q + 1'b1;
					end
					if (last_step) begin
						st_q <= ST_OUT;
					end else begin
						step_q <= step_q + 1'b1;
						idx_q  <= '0;
						st_q   <= ST_RD;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign res       = out_q;

endmodule

// File: rtl/tcp_session_translation_table_top.sv
// ----------------------------------------------------------------------------
// tcp_session_translation_table_top
// Session translation table for parsed TCP/IPv4 headers.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one header and a command per
// transaction; output channel (out_valid/out_stall) returns one rewritten
// header per transaction, in order.
// The front decodes the command and computes trim and length, then queues
// the item (two entries). The back scans the key memory one stored entry
// at a time: it reads each key from the single-port RAM in ST_RD and
// compares it in ST_CMP. A lookup reads the mapped tuple on a hit; an
// install runs four scan-and-insert passes. Only one item is in the
// engine at a time; the next one starts only after the previous result
// is loaded into the result register.
// Stored entries fill from index 0 upward and are tracked by a fill count,
// so reset empties the table at once; there is no clearing pass.
// When out_stall is high the result register holds its transaction; the
// engine finishes its next item and waits, and the queue keeps accepting
// until full, after which in_stall rises.
// ----------------------------------------------------------------------------
module tcp_session_translation_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_tcp_port,
	input  logic [15:0] dst_tcp_port,
	input  logic [31:0] super_src_addr,
	input  logic [31:0] super_dst_addr,
	input  logic [15:0] super_src_port,
	input  logic [15:0] super_dst_port,
	input  logic [15:0] ip_total_length,
	input  logic [3:0]  ip_header_words,
	input  logic [3:0]  tcp_offset_words,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_src_addr,
	output logic [31:0] out_dst_addr,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [15:0] out_ip_length,
	output logic [15:0] trim_bytes,
	output logic        hit,
	output logic        table_full
);
	import sttt_pkg::*;

	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	sttt_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.src_addr         (src_addr),
		.dst_addr         (dst_addr),
		.src_tcp_port     (src_tcp_port),
		.dst_tcp_port     (dst_tcp_port),
		.super_src_addr   (super_src_addr),
		.super_dst_addr   (super_dst_addr),
		.super_src_port   (super_src_port),
		.super_dst_port   (super_dst_port),
		.ip_total_length  (ip_total_length),
		.ip_header_words  (ip_header_words),
		.tcp_offset_words (tcp_offset_words),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_item           (q_item)
	);

	sttt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign out_src_addr  = res.tup.sa;
	assign out_dst_addr  = res.tup.da;
	assign out_src_port  = res.tup.sp;
	assign out_dst_port  = res.tup.dp;
	assign out_ip_length = res.ip_len;
	assign trim_bytes    = res.trim;
	assign hit           = res.hit;
	assign table_full    = res.full;

endmodule
